@@ rtl/core/erg_pkg.sv @@
// Shared types and constants for the Euclidean rhythm generator.
package erg_pkg;

  // Widths of the request and result fields.
  localparam int CNT_W = 5;
  localparam int PAT_W = 16;
  localparam int IN_W  = 16;

  typedef logic [CNT_W-1:0] cnt_t;

  // Sequencer states, one-hot coded.
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DIV   = 7'b0000010,
    ST_TAILB = 7'b0000100,
    ST_FINAL = 7'b0001000,
    ST_FINB  = 7'b0010000,
    ST_ROT   = 7'b0100000,
    ST_HOLD  = 7'b1000000
  } erg_state_t;

  // Control from the stream wrapper to the sequencer.
  typedef struct packed {
    logic start;
    logic take;
  } erg_ctl_t;

  // Status from the sequencer to the stream wrapper.
  typedef struct packed {
    logic idle;
    logic done;
    logic bad;
  } erg_sts_t;

endpackage

@@ rtl/core/erg_alu.sv @@
// Shared unit: compare and subtract on counts, append of one pattern segment to another.
module erg_alu import erg_pkg::*; #(
  parameter int MAX_STEPS = 16,
  parameter int PW        = MAX_STEPS,
  parameter int LW        = $clog2(MAX_STEPS + 1)
) (
  input  logic [PW-1:0] cur_bits,
  input  logic [LW-1:0] cur_len,
  input  logic [PW-1:0] add_bits,
  input  logic [LW-1:0] add_len,
  input  cnt_t          sub_a,
  input  cnt_t          sub_b,
  output logic [PW-1:0] cat_bits,
  output logic [LW-1:0] cat_len,
  output cnt_t          diff,
  output logic          ge
);

  logic [LW:0] len_sum;

  // Count arithmetic: one subtract and one compare.
  assign diff = sub_a - sub_b;
  assign ge   = (sub_a >= sub_b);

  // Append: the new segment goes above the current one; anything past the cap drops off.
  assign cat_bits = cur_bits | (add_bits << cur_len);
  assign len_sum  = {1'b0, cur_len} + {1'b0, add_len};
  assign cat_len  = (len_sum > (LW+1)'(MAX_STEPS)) ? LW'(MAX_STEPS) : len_sum[LW-1:0];

endmodule

@@ rtl/core/erg_core.sv @@
// Sequencer that runs the division chain, builds the rhythm level by level and rotates it.
module erg_core import erg_pkg::*; #(
  parameter int MAX_STEPS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  erg_ctl_t         ctl,
  input  cnt_t             step_count,
  input  cnt_t             pulse_count,
  output erg_sts_t         sts,
  output logic [PAT_W-1:0] pattern
);

  localparam int PW = MAX_STEPS;
  localparam int LW = $clog2(MAX_STEPS + 1);

  erg_state_t state, state_next;

  // Division chain: running dividend and current remainder.
  cnt_t dvd, dvd_next;
  cnt_t rr, rr_next;
  // Segment of the previous level (a), of the level before it (b), and the one being built.
  logic [PW-1:0] pa, pa_next, pb, pb_next, pc, pc_next;
  logic [LW-1:0] la, la_next, lb, lb_next, lc, lc_next;
  logic          bad, bad_next;

  logic [PW-1:0] add_bits, cat_bits;
  logic [LW-1:0] add_len, cat_len;
  cnt_t          sub_a, sub_b, diff;
  logic          ge;
  logic          refuse;

  erg_alu #(
    .MAX_STEPS (MAX_STEPS),
    .PW        (PW),
    .LW        (LW)
  ) u_alu (
    .cur_bits (pc),
    .cur_len  (lc),
    .add_bits (add_bits),
    .add_len  (add_len),
    .sub_a    (sub_a),
    .sub_b    (sub_b),
    .cat_bits (cat_bits),
    .cat_len  (cat_len),
    .diff     (diff),
    .ge       (ge)
  );

  // Operand selection for the shared unit.
  always_comb begin
    case (state)
      ST_IDLE: begin
        sub_a = step_count;
        sub_b = pulse_count;
      end
      ST_FINAL: begin
        sub_a = dvd;
        sub_b = cnt_t'(1);
      end
      default: begin
        sub_a = dvd;
        sub_b = rr;
      end
    endcase
    if (state == ST_TAILB || state == ST_FINB) begin
      add_bits = pb;
      add_len  = lb;
    end else begin
      add_bits = pa;
      add_len  = la;
    end
  end

  // A request is refused when pulses exceed steps or steps exceed the pattern size.
  assign refuse = !ge || (32'(step_count) > MAX_STEPS);

  // Next-state and datapath updates.
  always_comb begin
    state_next = state;
    dvd_next   = dvd;
    rr_next    = rr;
    pa_next    = pa;
    la_next    = la;
    pb_next    = pb;
    lb_next    = lb;
    pc_next    = pc;
    lc_next    = lc;
    bad_next   = bad;
    case (state)
      ST_IDLE: begin
        if (ctl.start) begin
          bad_next = refuse;
          if (refuse || pulse_count == '0) begin
            pc_next    = '0;
            state_next = ST_HOLD;
          end else begin
            dvd_next   = diff;
            rr_next    = pulse_count;
            pa_next    = '0;
            la_next    = LW'(1);
            pb_next    = PW'(1);
            lb_next    = LW'(1);
            pc_next    = '0;
            lc_next    = '0;
            state_next = ST_DIV;
          end
        end
      end
      // One subtraction per cycle; each one adds a copy of the previous level.
      ST_DIV: begin
        if (ge) begin
          dvd_next = diff;
          pc_next  = cat_bits;
          lc_next  = cat_len;
        end else begin
          state_next = ST_TAILB;
        end
      end
      // Close the level with the level below the previous one and step down the chain.
      ST_TAILB: begin
        pb_next  = pa;
        lb_next  = la;
        pa_next  = cat_bits;
        la_next  = cat_len;
        pc_next  = '0;
        lc_next  = '0;
        dvd_next = rr;
        rr_next  = dvd;
        if (dvd[CNT_W-1:1] == '0) begin
          state_next = ST_FINAL;
        end else begin
          state_next = ST_DIV;
        end
      end
      // Top level: as many copies of the previous level as the last divisor.
      ST_FINAL: begin
        if (ge) begin
          dvd_next = diff;
          pc_next  = cat_bits;
          lc_next  = cat_len;
        end else begin
          state_next = ST_FINB;
        end
      end
      // A remainder of one adds a final copy of the level below.
      ST_FINB: begin
        if (rr[0]) begin
          pc_next = cat_bits;
          lc_next = cat_len;
        end
        state_next = ST_ROT;
      end
      // Leading rests move to the end, one step per cycle.
      ST_ROT: begin
        if (!pc[0] && pc != '0) begin
          pc_next = pc >> 1;
        end else begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (ctl.take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    dvd <= dvd_next;
    rr  <= rr_next;
    pa  <= pa_next;
    la  <= la_next;
    pb  <= pb_next;
    lb  <= lb_next;
    pc  <= pc_next;
    lc  <= lc_next;
    bad <= bad_next;
  end

  // Status and result.
  assign sts.idle = (state == ST_IDLE);
  assign sts.done = (state == ST_HOLD);
  assign sts.bad  = bad;
  assign pattern  = PAT_W'(pc);

endmodule

@@ rtl/core/euclidean_rhythm_generator_unit.sv @@
// A refused or all-rest request goes straight to the result; otherwise the sequencer runs
//   the division chain level by level and then rotates out the leading rests, all on the
//   single subtract-and-append unit.
// Throughput: one request at a time; the next is taken once the result moves to the output
//   register. Reset: synchronous, active high; clears the sequencer and the output valid.
module euclidean_rhythm_generator_unit import erg_pkg::*; #(
  parameter int MAX_STEPS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [IN_W-1:0] s_tdata,   // [4:0] step_count, [9:5] pulse_count, rest zero
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [PAT_W-1:0] m_tdata,  // [15:0] pattern
  output logic            m_tuser    // [0] bad_request
);

  erg_ctl_t         ctl;
  erg_sts_t         sts;
  logic [PAT_W-1:0] core_pattern;

  erg_core #(
    .MAX_STEPS (MAX_STEPS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .step_count  (s_tdata[CNT_W-1:0]),
    .pulse_count (s_tdata[2*CNT_W-1:CNT_W]),
    .sts         (sts),
    .pattern     (core_pattern)
  );

  // Request side: taken whenever the sequencer is idle.
  assign s_tready  = sts.idle;
  assign ctl.start = s_tvalid && sts.idle;
  // Finished result moves to the output register once it is free.
  assign ctl.take  = sts.done && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      m_tdata <= core_pattern;
      m_tuser <= sts.bad;
    end
  end

endmodule

@@ rtl/core/erg_chk.sv @@
// Port-level checks for the Euclidean rhythm generator, bound to the top level.
module erg_chk import erg_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [PAT_W-1:0] m_tdata,
  input logic             m_tuser
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // A refused request always reports an empty pattern.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("refused request with nonzero pattern");

  // A nonempty rhythm starts with a pulse.
  a_first: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata != '0 |-> m_tdata[0])
    else $error("rhythm does not start with a pulse");

  // The block is busy in the cycle after it takes a request.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready right after a request");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind euclidean_rhythm_generator_unit erg_chk u_erg_chk (.*);

@@ bench/euclidean_rhythm_generator_unit_tb.sv @@
// Self-checking testbench for the Euclidean rhythm generator stream unit.
module euclidean_rhythm_generator_unit_tb import erg_pkg::*; ();

  localparam int MAX_STEPS   = 16;
  localparam int LEVEL_SLOTS = MAX_STEPS + 2;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 3 * MAX_STEPS + 40;

  // One expected result: pattern and refusal flag.
  typedef struct packed {
    logic [PAT_W-1:0] pattern;
    logic             bad;
  } rhythm_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;   // [4:0] step_count, [9:5] pulse_count, rest zero
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [PAT_W-1:0] m_tdata;        // [15:0] pattern
  logic             m_tuser;        // [0] bad_request

  rhythm_t expected_rhythms[$];
  int      tx_idle_pct = 0;
  int      rx_idle_pct = 0;
  int      n_errors    = 0;
  int      n_sent      = 0;
  int      n_refused   = 0;
  int      n_all_rest  = 0;
  int      n_checked   = 0;
  int      cycle_count = 0;

  euclidean_rhythm_generator_unit #(
    .MAX_STEPS(MAX_STEPS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Free-running clock.
  initial begin
    forever #2 clk = ~clk;
  end

  // Run guard: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Euclidean rhythm for one request: division chain, level expansion, then
  // rotation so that the first pulse lands on step 0.
  function automatic rhythm_t predict_rhythm(input cnt_t steps, input cnt_t pulses);
    rhythm_t          res;
    int unsigned      quo [0:LEVEL_SLOTS-1];
    int unsigned      rmd [0:LEVEL_SLOTS-1];
    int unsigned      divisor;
    int unsigned      len;
    int               lvl;
    int               cur;
    int               k;
    int               first;
    int               pending[$];
    logic [PAT_W-1:0] bits;
    logic [PAT_W-1:0] rot;
    res.pattern = '0;
    res.bad     = 1'b0;
    if (pulses > steps || steps > MAX_STEPS) begin
      res.bad = 1'b1;
      return res;
    end
    if (pulses == 0)
      return res;

    // Division chain: quotients and remainders per level.
    divisor = steps - pulses;
    rmd[0]  = pulses;
    lvl     = 0;
    while (1) begin
      quo[lvl]     = divisor / rmd[lvl];
      rmd[lvl + 1] = divisor % rmd[lvl];
      divisor      = rmd[lvl];
      lvl++;
      if (rmd[lvl] <= 1 || lvl + 1 >= LEVEL_SLOTS)
        break;
    end
    quo[lvl] = divisor;

    // Expansion with an explicit stack; level -1 is a rest, level -2 a pulse.
    bits = '0;
    len  = 0;
    pending.push_back(lvl);
    while (pending.size() > 0) begin
      cur = pending.pop_back();
      if (cur == -1 || cur == -2) begin
        if (len < MAX_STEPS) begin
          if (cur == -2)
            bits[len] = 1'b1;
          len++;
        end
      end else if (cur >= 0) begin
        // Pushed in reverse so the lower-level copies expand first.
        if (rmd[cur] != 0)
          pending.push_back(cur - 2);
        for (k = 0; k < quo[cur]; k++)
          pending.push_back(cur - 1);
      end
    end

    // Rotate so that the first pulse sits at step 0.
    first = 0;
    while (first < len && !bits[first])
      first++;
    rot = bits;
    if (first > 0 && first < len) begin
      rot = '0;
      for (k = 0; k < len; k++)
        rot[k] = bits[(k + first) % len];
    end
    res.pattern = rot;
    return res;
  endfunction

  // Result sink with random backpressure.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Compare each accepted result with the oldest outstanding request.
  always @(posedge clk) begin : check_results
    rhythm_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_rhythms.size() == 0) begin
        $error("unexpected result: pattern %h bad_request %b", m_tdata, m_tuser);
        n_errors++;
      end else begin
        want = expected_rhythms.pop_front();
        n_checked++;
        if (m_tdata !== want.pattern) begin
          $error("pattern mismatch: expected %h, actual %h", want.pattern, m_tdata);
          n_errors++;
        end
        if (m_tuser !== want.bad) begin
          $error("bad_request mismatch: expected %b, actual %b", want.bad, m_tuser);
          n_errors++;
        end
      end
    end
  end

  // Send one request; called and returning at a falling edge.
  task automatic send_request(input cnt_t steps, input cnt_t pulses);
    rhythm_t want;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {6'b0, pulses, steps};
    do @(posedge clk); while (!s_tready);
    want = predict_rhythm(steps, pulses);
    expected_rhythms.push_back(want);
    n_sent++;
    if (want.bad)
      n_refused++;
    else if (want.pattern == '0)
      n_all_rest++;
    @(negedge clk);
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic wait_results_drained();
    s_tvalid = 1'b0;
    while (expected_rhythms.size() != 0)
      @(negedge clk);
  endtask

  // Corner requests: empty and full rhythms, refusals and known rhythms.
  task automatic test_directed_cases();
    send_request(5'd1, 5'd0);
    send_request(5'd1, 5'd1);
    send_request(5'd16, 5'd16);
    send_request(5'd16, 5'd0);
    send_request(5'd16, 5'd1);
    send_request(5'd16, 5'd15);
    send_request(5'd8, 5'd3);
    send_request(5'd8, 5'd5);
    send_request(5'd13, 5'd5);
    send_request(5'd12, 5'd7);
    send_request(5'd16, 5'd9);
    send_request(5'd0, 5'd0);
    send_request(5'd0, 5'd1);
    send_request(5'd3, 5'd4);
    send_request(5'd17, 5'd1);
    send_request(5'd31, 5'd31);
    send_request(5'd31, 5'd0);
    send_request(5'd16, 5'd17);
    send_request(5'd5, 5'd31);
    send_request(5'd2, 5'd1);
    send_request(5'd9, 5'd4);
    send_request(5'd7, 5'd3);
    send_request(5'd16, 5'd5);
    send_request(5'd15, 5'd14);
    send_request(5'd10, 5'd4);
  endtask

  // Random requests, mostly well formed, the rest refused or arbitrary.
  task automatic test_random_requests(input int count);
    int   pick;
    cnt_t steps;
    cnt_t pulses;
    for (int i = 0; i < count; i++) begin
      pick = int'($urandom_range(99));
      if (pick < 80) begin
        steps  = cnt_t'($urandom_range(MAX_STEPS, 1));
        pulses = cnt_t'($urandom_range(steps, 0));
      end else if (pick < 90) begin
        steps  = cnt_t'($urandom_range(MAX_STEPS - 1, 0));
        pulses = cnt_t'($urandom_range(31, steps + 1));
      end else begin
        steps  = cnt_t'($urandom_range(31));
        pulses = cnt_t'($urandom_range(31));
      end
      send_request(steps, pulses);
    end
  endtask

  // Main sequence.
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Sender idles lightly, receiver heavily.
    tx_idle_pct = 19;
    rx_idle_pct = 52;
    test_directed_cases();
    test_random_requests(180);
    wait_results_drained();

    // Roles swapped.
    tx_idle_pct = 52;
    rx_idle_pct = 19;
    test_random_requests(180);
    wait_results_drained();

    // Back to back on both sides.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_requests(190);
    wait_results_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d rhythm requests (%0d refused, %0d all-rest) under three idle mixes.",
             n_sent, n_refused, n_all_rest);
    $display("Checked %0d results, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
